// ===== rtl/fpfa_pkg.sv =====
// Shared types and codes for the fixed partition fit allocator.
package fpfa_pkg;

  // Operation codes on the input channel.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Placement policy codes held in the policy register.
  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [0:0] CFG_POLICY = 1'b0;
  localparam logic [0:0] CFG_COUNT  = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int IDX_W      = 4;
  localparam int SZ_W       = 16;
  localparam int TAG_W      = 8;

  // Reset values of the configuration registers.
  localparam logic [1:0] POLICY_RST = POL_BEST;
  localparam logic [4:0] COUNT_RST  = 5'd16;

  // Queue depths between the front, the back and the result port.
  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  // Command class decided by the front end.
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_LOAD,
    KIND_ALLOC,
    KIND_RELEASE
  } kind_t;

  // Decoded command passed from the front end to the back end.
  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
    logic [SZ_W-1:0]   size;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } cmd_t;

  // Result transaction.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [SZ_W-1:0]   size;
    logic [SZ_W-1:0]   left;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } res_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [1:0] policy;
    logic [4:0] count;
  } cfg_t;

endpackage

// ===== rtl/fpfa_fifo.sv =====
// Small synchronous queue used between the allocator stages.
module fpfa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Storage for queued transactions.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/fpfa_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
module fpfa_front #(
  parameter int MAX_PARTITIONS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [1:0]                   in_op,
  input  logic [fpfa_pkg::IDX_W-1:0]   in_partition_index,
  input  logic [fpfa_pkg::SZ_W-1:0]    in_partition_size,
  input  logic [fpfa_pkg::SZ_W-1:0]    in_request_size,
  input  logic [fpfa_pkg::TAG_W-1:0]   in_request_tag,
  input  logic                         in_last_request,
  output logic                         in_full,
  input  logic                         cmd_pop,
  output fpfa_pkg::cmd_t               cmd,
  output logic                         cmd_empty
);

  fpfa_pkg::cmd_t cls;

  // Classify the operation; loads outside the table and undefined ops do nothing.
  always_comb begin
    cls.idx  = in_partition_index;
    cls.tag  = in_request_tag;
    cls.last = in_last_request;
    cls.size = in_request_size;
    unique case (in_op)
      fpfa_pkg::OP_LOAD: begin
        cls.kind = (32'(in_partition_index) < 32'(MAX_PARTITIONS)) ?
                   fpfa_pkg::KIND_LOAD : fpfa_pkg::KIND_NOP;
        cls.size = in_partition_size;
      end
      fpfa_pkg::OP_ALLOC:   cls.kind = fpfa_pkg::KIND_ALLOC;
      fpfa_pkg::OP_RELEASE: cls.kind = fpfa_pkg::KIND_RELEASE;
      default:              cls.kind = fpfa_pkg::KIND_NOP;
    endcase
  end

  // Command queue toward the back end.
  fpfa_fifo #(
    .WIDTH ($bits(fpfa_pkg::cmd_t)),
    .DEPTH (fpfa_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// ===== rtl/fpfa_back.sv =====
// Back end: holds the partition table and free flags and executes commands.
module fpfa_back #(
  parameter int MAX_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fpfa_pkg::cfg_t cfg,
  input  logic           cmd_empty,
  input  fpfa_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output fpfa_pkg::res_t res
);

  localparam int IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                    state_r, state_nxt;
  logic [IW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]             last_idx_r, last_idx_nxt;
  logic                      issue_done_r, issue_done_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic                      have_r, have_nxt;
  logic [IW-1:0]             best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0]      best_size_r, best_size_nxt;
  logic [SIZE_BITS-1:0]      best_left_r, best_left_nxt;
  logic [SIZE_BITS-1:0]      req_r, req_nxt;
  logic [fpfa_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic                      last_r, last_nxt;
  logic [MAX_PARTITIONS-1:0] free_r, free_nxt;

  logic [SIZE_BITS-1:0]      size_mem [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0]      mem_q;

  logic                      start;
  logic                      mem_we;
  logic [SIZE_BITS-1:0]      cmd_size;
  logic [31:0]               cnt_ext;
  logic                      has_parts;
  logic [IW-1:0]             last_idx_calc;
  logic                      fits;
  logic                      take;
  logic [SIZE_BITS-1:0]      left;

  assign start    = (state_r == ST_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop  = start;
  assign cmd_size = SIZE_BITS'(cmd.size);
  assign mem_we   = start && (cmd.kind == fpfa_pkg::KIND_LOAD);

  // Number of entries that take part, saturated to the table depth.
  assign cnt_ext       = 32'(cfg.count);
  assign has_parts     = (cnt_ext != 32'd0);
  assign last_idx_calc = (cnt_ext >= 32'(MAX_PARTITIONS)) ? IW'(MAX_PARTITIONS - 1) :
                         IW'(cnt_ext - 32'd1);

  // Size table: written by loads, read one entry a cycle during a scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[IW'(cmd.idx)] <= cmd_size;
    end
    mem_q <= size_mem[rd_idx_r];
  end

  // Candidate evaluation for the entry whose size just came out of the table.
  assign fits = cmp_vld_r && free_r[cmp_idx_r] && (mem_q >= req_r);
  assign left = mem_q - req_r;

  always_comb begin
    unique case (cfg.policy)
      fpfa_pkg::POL_FIRST: take = !have_r;
      fpfa_pkg::POL_WORST: take = !have_r || (left > best_left_r);
      default:             take = !have_r || (left < best_left_r);
    endcase
  end

  // Result assembly and push toward the result queue.
  always_comb begin
    res      = '0;
    res_push = 1'b0;
    if (state_r == ST_FINISH) begin
      res_push  = 1'b1;
      res.found = have_r;
      res.tag   = tag_r;
      res.last  = last_r;
      if (have_r) begin
        res.idx  = fpfa_pkg::IDX_W'(best_idx_r);
        res.size = fpfa_pkg::SZ_W'(best_size_r);
        res.left = fpfa_pkg::SZ_W'(best_left_r);
      end
    end else if (start) begin
      res.tag  = cmd.tag;
      res.last = cmd.last;
      res_push = (cmd.kind != fpfa_pkg::KIND_ALLOC) || !has_parts;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    last_idx_nxt   = last_idx_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    have_nxt       = have_r;
    best_idx_nxt   = best_idx_r;
    best_size_nxt  = best_size_r;
    best_left_nxt  = best_left_r;
    req_nxt        = req_r;
    tag_nxt        = tag_r;
    last_nxt       = last_r;
    free_nxt       = free_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (cmd.kind == fpfa_pkg::KIND_RELEASE) begin
            free_nxt = '1;
          end
          if ((cmd.kind == fpfa_pkg::KIND_ALLOC) && has_parts) begin
            state_nxt      = ST_SCAN;
            rd_idx_nxt     = '0;
            last_idx_nxt   = last_idx_calc;
            issue_done_nxt = 1'b0;
            have_nxt       = 1'b0;
            req_nxt        = cmd_size;
            tag_nxt        = cmd.tag;
            last_nxt       = cmd.last;
          end
        end
      end
      ST_SCAN: begin
        // Issue one table read a cycle until the last entry is addressed.
        if (!issue_done_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          if (rd_idx_r == last_idx_r) begin
            issue_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        // Compare the entry read in the previous cycle.
        if (fits && take) begin
          have_nxt      = 1'b1;
          best_idx_nxt  = cmp_idx_r;
          best_size_nxt = mem_q;
          best_left_nxt = left;
        end
        if (cmp_vld_r && (cmp_idx_r == last_idx_r)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (have_r) begin
          free_nxt[best_idx_r] = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b1;
      cmp_vld_r    <= 1'b0;
      have_r       <= 1'b0;
      free_r       <= '1;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      have_r       <= have_nxt;
      free_r       <= free_nxt;
    end
    rd_idx_r    <= rd_idx_nxt;
    last_idx_r  <= last_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    best_left_r <= best_left_nxt;
    req_r       <= req_nxt;
    tag_r       <= tag_nxt;
    last_r      <= last_nxt;
  end

endmodule

// ===== rtl/fixed_partition_fit_allocator.sv =====
// Load, release, undefined ops and an allocate with no entry in use need no scan; the back end
// pushes their result into the result queue in the cycle in which it takes the command.
// An allocate holds the back end from acceptance until its result is pushed: it scans the first
// n = min(partitions_in_use, MAX_PARTITIONS) entries of the size table, one entry per cycle.
// Throughput: one non-allocate per cycle while the result queue has room.
// Reset: all partitions free, policy best fit, 16 partitions in use; sizes are not cleared.
module fixed_partition_fit_allocator #(
  parameter int MAX_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [1:0]                        in_op,
  input  logic [fpfa_pkg::IDX_W-1:0]        in_partition_index,
  input  logic [fpfa_pkg::SZ_W-1:0]         in_partition_size,
  input  logic [fpfa_pkg::SZ_W-1:0]         in_request_size,
  input  logic [fpfa_pkg::TAG_W-1:0]        in_request_tag,
  input  logic                              in_last_request,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_found,
  output logic [fpfa_pkg::IDX_W-1:0]        out_chosen_index,
  output logic [fpfa_pkg::SZ_W-1:0]         out_chosen_size,
  output logic [fpfa_pkg::SZ_W-1:0]         out_leftover,
  output logic [fpfa_pkg::TAG_W-1:0]        out_tag_out,
  output logic                              out_end_of_batch,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fpfa_pkg::cfg_t cfg_r;
  fpfa_pkg::cmd_t cmd;
  fpfa_pkg::res_t res_in;
  fpfa_pkg::res_t res_out;
  logic           cmd_empty;
  logic           cmd_pop;
  logic           res_full;
  logic           res_push;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy <= fpfa_pkg::POLICY_RST;
      cfg_r.count  <= fpfa_pkg::COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpfa_pkg::CFG_POLICY: cfg_r.policy <= cfg_data[1:0];
        fpfa_pkg::CFG_COUNT:  cfg_r.count  <= cfg_data;
        default:              cfg_r        <= cfg_r;
      endcase
    end
  end

  // Front end with its command queue.
  fpfa_front #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_op              (in_op),
    .in_partition_index (in_partition_index),
    .in_partition_size  (in_partition_size),
    .in_request_size    (in_request_size),
    .in_request_tag     (in_request_tag),
    .in_last_request    (in_last_request),
    .in_full            (in_full),
    .cmd_pop            (cmd_pop),
    .cmd                (cmd),
    .cmd_empty          (cmd_empty)
  );

  // Back end: table, free flags and scan sequencer.
  fpfa_back #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue toward the output port.
  fpfa_fifo #(
    .WIDTH ($bits(fpfa_pkg::res_t)),
    .DEPTH (fpfa_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_found        = res_out.found;
  assign out_chosen_index = res_out.idx;
  assign out_chosen_size  = res_out.size;
  assign out_leftover     = res_out.left;
  assign out_tag_out      = res_out.tag;
  assign out_end_of_batch = res_out.last;

endmodule

// ===== tb/sv/fixed_partition_fit_allocator_test.sv =====
// Self-checking testbench for the fixed partition fit allocator.
`timescale 1ns / 100ps

module fixed_partition_fit_allocator_test;

  // The op code and the policy code that the package leaves undefined.
  localparam logic [1:0] OP_UNDEF  = 2'd3;
  localparam logic [1:0] POL_UNDEF = 2'd3;

  localparam int TABLE_DEPTH  = 16;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  // One input transaction as the testbench keeps it.
  typedef struct packed {
    logic [1:0]                 op;
    logic [fpfa_pkg::IDX_W-1:0] slot;
    logic [fpfa_pkg::SZ_W-1:0]  slot_size;
    logic [fpfa_pkg::SZ_W-1:0]  want;
    logic [fpfa_pkg::TAG_W-1:0] tag;
    logic                       last;
  } alloc_cmd_t;

  logic                            clk                = 1'b0;
  logic                            rst_n              = 1'b0;
  logic                            in_push            = 1'b0;
  logic                            in_full;
  logic [1:0]                      in_op              = '0;
  logic [fpfa_pkg::IDX_W-1:0]      in_partition_index = '0;
  logic [fpfa_pkg::SZ_W-1:0]       in_partition_size  = '0;
  logic [fpfa_pkg::SZ_W-1:0]       in_request_size    = '0;
  logic [fpfa_pkg::TAG_W-1:0]      in_request_tag     = '0;
  logic                            in_last_request    = 1'b0;
  logic                            out_empty;
  logic                            out_pop            = 1'b0;
  logic                            out_found;
  logic [fpfa_pkg::IDX_W-1:0]      out_chosen_index;
  logic [fpfa_pkg::SZ_W-1:0]       out_chosen_size;
  logic [fpfa_pkg::SZ_W-1:0]       out_leftover;
  logic [fpfa_pkg::TAG_W-1:0]      out_tag_out;
  logic                            out_end_of_batch;
  logic                            cfg_valid          = 1'b0;
  logic                            cfg_ready;
  logic [fpfa_pkg::CFG_IDX_W-1:0]  cfg_index          = '0;
  logic [fpfa_pkg::CFG_DATA_W-1:0] cfg_data           = '0;

  // Mirror of the allocator state and its registers.
  logic [fpfa_pkg::SZ_W-1:0] part_size [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    part_free = '1;
  logic [1:0]                policy_reg = fpfa_pkg::POLICY_RST;
  logic [4:0]                count_reg  = fpfa_pkg::COUNT_RST;

  alloc_cmd_t     cmd_backlog[$];
  fpfa_pkg::res_t allocations_due[$];
  alloc_cmd_t     cmd_live;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  // Register settings of the random phases.
  logic [4:0] policy_plan [8] = '{{3'b000, fpfa_pkg::POL_BEST}, {3'b000, fpfa_pkg::POL_FIRST},
                                  {3'b000, fpfa_pkg::POL_WORST}, {3'b000, POL_UNDEF},
                                  {3'b000, fpfa_pkg::POL_FIRST}, {3'b000, fpfa_pkg::POL_WORST},
                                  {3'b000, fpfa_pkg::POL_BEST}, {3'b111, fpfa_pkg::POL_FIRST}};
  logic [4:0] count_plan [8]  = '{5'd16, 5'd1, 5'd16, 5'd31, 5'd0, 5'd7, 5'd16, 5'd16};
  int         items_plan [8]  = '{75, 75, 75, 75, 25, 75, 75, 75};

  fixed_partition_fit_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_op              (in_op),
    .in_partition_index (in_partition_index),
    .in_partition_size  (in_partition_size),
    .in_request_size    (in_request_size),
    .in_request_tag     (in_request_tag),
    .in_last_request    (in_last_request),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_found          (out_found),
    .out_chosen_index   (out_chosen_index),
    .out_chosen_size    (out_chosen_size),
    .out_leftover       (out_leftover),
    .out_tag_out        (out_tag_out),
    .out_end_of_batch   (out_end_of_batch),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #6 clk = ~clk;

  // Applies one accepted transaction to the mirrored state and returns its result.
  function automatic fpfa_pkg::res_t predict_allocation(input alloc_cmd_t c);
    fpfa_pkg::res_t             r;
    int                         span;
    int                         j;
    bit                         have;
    logic [fpfa_pkg::IDX_W-1:0] pick;
    logic [fpfa_pkg::SZ_W-1:0]  pick_left;
    logic [fpfa_pkg::SZ_W-1:0]  left;
    r = '0;
    r.tag = c.tag;
    r.last = c.last;
    case (c.op)
      fpfa_pkg::OP_LOAD: begin
        part_size[c.slot] = c.slot_size;
      end
      fpfa_pkg::OP_RELEASE: begin
        part_free = '1;
      end
      fpfa_pkg::OP_ALLOC: begin
        span = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
        have = 1'b0;
        pick = '0;
        pick_left = '0;
        for (j = 0; j < span; j++) begin
          if (part_free[j] && part_size[j] >= c.want) begin
            left = part_size[j] - c.want;
            // Ties keep the lower index, since only a strict improvement wins.
            if (policy_reg == fpfa_pkg::POL_FIRST) begin
              if (!have) begin
                have = 1'b1;
                pick = fpfa_pkg::IDX_W'(j);
                pick_left = left;
              end
            end else if (policy_reg == fpfa_pkg::POL_WORST) begin
              if (!have || left > pick_left) begin
                have = 1'b1;
                pick = fpfa_pkg::IDX_W'(j);
                pick_left = left;
              end
            end else begin
              if (!have || left < pick_left) begin
                have = 1'b1;
                pick = fpfa_pkg::IDX_W'(j);
                pick_left = left;
              end
            end
          end
        end
        if (have) begin
          part_free[pick] = 1'b0;
          r.found = 1'b1;
          r.idx = pick;
          r.size = part_size[pick];
          r.left = pick_left;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic alloc_cmd_t make_cmd(input logic [1:0] op,
                                          input logic [fpfa_pkg::IDX_W-1:0] slot,
                                          input logic [fpfa_pkg::SZ_W-1:0] slot_size,
                                          input logic [fpfa_pkg::SZ_W-1:0] want,
                                          input logic [fpfa_pkg::TAG_W-1:0] tag,
                                          input logic last);
    alloc_cmd_t c;
    c.op = op;
    c.slot = slot;
    c.slot_size = slot_size;
    c.want = want;
    c.tag = tag;
    c.last = last;
    return c;
  endfunction

  // Writes one register through the configuration channel and mirrors it.
  task automatic write_register(input logic [fpfa_pkg::CFG_IDX_W-1:0] idx,
                                input logic [fpfa_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fpfa_pkg::CFG_POLICY) begin
      policy_reg = data[1:0];
    end else begin
      count_reg = data;
    end
  endtask

  // Waits until every transaction has been sent and every result has come back.
  task automatic wait_quiet();
    do @(negedge clk); while (cmd_backlog.size() != 0 || in_push || allocations_due.size() != 0);
  endtask

  // Request driver: presents the backlog in order, with random gaps.
  always @(posedge clk) begin : drive_requests
    logic take_next;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      take_next = !in_push || !in_full;
      if (in_push && !in_full) begin
        allocations_due.push_back(predict_allocation(cmd_live));
      end
      if (take_next) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_live = cmd_backlog.pop_front();
          in_op <= cmd_live.op;
          in_partition_index <= cmd_live.slot;
          in_partition_size <= cmd_live.slot_size;
          in_request_size <= cmd_live.want;
          in_request_tag <= cmd_live.tag;
          in_last_request <= cmd_live.last;
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each popped result against the oldest expectation.
  always @(posedge clk) begin : check_results
    fpfa_pkg::res_t exp_r;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (allocations_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected result transaction, tag %0d", out_tag_out);
          end
        end else begin
          exp_r = allocations_due.pop_front();
          if (out_found !== exp_r.found || out_chosen_index !== exp_r.idx ||
              out_chosen_size !== exp_r.size || out_leftover !== exp_r.left ||
              out_tag_out !== exp_r.tag || out_end_of_batch !== exp_r.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("mismatch: expected found=%b idx=%0d size=%0d left=%0d tag=%0d last=%b",
                       exp_r.found, exp_r.idx, exp_r.size, exp_r.left, exp_r.tag, exp_r.last);
              $display("          actual   found=%b idx=%0d size=%0d left=%0d tag=%0d last=%b",
                       out_found, out_chosen_index, out_chosen_size, out_leftover,
                       out_tag_out, out_end_of_batch);
            end
          end
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [fpfa_pkg::SZ_W-1:0] seed_sizes [TABLE_DEPTH];
    alloc_cmd_t                c;
    int                        k;
    int                        i;
    int unsigned               roll;

    seed_sizes = '{16'd0, 16'd100, 16'd500, 16'd100, 16'hFFFF, 16'd300, 16'd1000, 16'd50,
                   16'd2000, 16'd100, 16'd700, 16'hFFFF, 16'd20, 16'd4000, 16'd300, 16'd9000};
    count_plan[7] = 5'($urandom_range(1, TABLE_DEPTH));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset settings: every entry loaded first, so no scan
    // ever reads a size that was never written.
    for (i = 0; i < TABLE_DEPTH; i++) begin
      cmd_backlog.push_back(make_cmd(fpfa_pkg::OP_LOAD, fpfa_pkg::IDX_W'(i), seed_sizes[i],
                                     fpfa_pkg::SZ_W'($urandom), fpfa_pkg::TAG_W'(i), i[0]));
    end
    // Zero request picks the empty partition; full-size requests drain the two
    // largest and then find nothing; a tie goes to the lower index.
    cmd_backlog.push_back(make_cmd(fpfa_pkg::OP_ALLOC, 4'd15, fpfa_pkg::SZ_W'($urandom),
                                   16'd0, 8'hFF, 1'b0));
    cmd_backlog.push_back(make_cmd(fpfa_pkg::OP_ALLOC, 4'd0, fpfa_pkg::SZ_W'($urandom),
                                   16'hFFFF, 8'd1, 1'b0));
    cmd_backlog.push_back(make_cmd(fpfa_pkg::OP_ALLOC, 4'd0, fpfa_pkg::SZ_W'($urandom),
                                   16'hFFFF, 8'd2, 1'b0));
    cmd_backlog.push_back(make_cmd(fpfa_pkg::OP_ALLOC, 4'd0, fpfa_pkg::SZ_W'($urandom),
                                   16'hFFFF, 8'd3, 1'b1));
    cmd_backlog.push_back(make_cmd(fpfa_pkg::OP_ALLOC, 4'd0, fpfa_pkg::SZ_W'($urandom),
                                   16'd100, 8'd4, 1'b0));
    // The undefined op changes nothing.
    cmd_backlog.push_back(make_cmd(OP_UNDEF, 4'd15, 16'hFFFF, 16'd0, 8'h5A, 1'b1));
    cmd_backlog.push_back(make_cmd(fpfa_pkg::OP_RELEASE, 4'd0, 16'd0, 16'd0, 8'd0, 1'b1));
    cmd_backlog.push_back(make_cmd(fpfa_pkg::OP_ALLOC, 4'd0, 16'hFFFF, 16'd1, 8'hFF, 1'b1));
    wait_quiet();

    // Random phases, each with its own register settings and idling pattern.
    for (k = 0; k < 8; k++) begin
      write_register(fpfa_pkg::CFG_POLICY, policy_plan[k]);
      write_register(fpfa_pkg::CFG_COUNT, count_plan[k]);
      case (k % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
      endcase
      for (i = 0; i < items_plan[k]; i++) begin
        c = make_cmd(fpfa_pkg::OP_ALLOC, fpfa_pkg::IDX_W'($urandom_range(TABLE_DEPTH - 1)),
                     fpfa_pkg::SZ_W'($urandom), fpfa_pkg::SZ_W'($urandom),
                     fpfa_pkg::TAG_W'($urandom), 1'($urandom_range(1)));
        roll = $urandom_range(99);
        // Mostly requests against a table of coarse sizes, so that ties, good
        // fits and exhaustion all occur; releases reopen the table now and then.
        if (roll < 62) begin
          if ($urandom_range(3) != 0) c.want = fpfa_pkg::SZ_W'($urandom_range(0, 800));
        end else if (roll < 82) begin
          c.op = fpfa_pkg::OP_LOAD;
          if ($urandom_range(3) != 0) begin
            c.slot_size = fpfa_pkg::SZ_W'($urandom_range(0, 8) * 100);
          end
        end else if (roll < 91) begin
          c.op = fpfa_pkg::OP_RELEASE;
        end else if (roll < 95) begin
          c.op = OP_UNDEF;
        end
        cmd_backlog.push_back(c);
      end
      wait_quiet();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
